[sv/fnvit_pkg.sv]
package fnvit_pkg;

  localparam logic [63:0] FnvOffsetBasis = 64'hCBF29CE484222325;
  localparam logic [63:0] FnvPrime       = 64'h00000100000001B3;

  // one fnv-1a round: xor the byte, multiply by the prime mod 2^64
  // the prime is 2^40 + 0x1b3, so the product is a sum of shifted copies
  function automatic logic [63:0] fnv_round(input logic [63:0] hash, input logic [7:0] data);
    logic [63:0] x;
    x = hash ^ {56'd0, data};
    return x + (x << 1) + (x << 4) + (x << 5) + (x << 7) + (x << 8) + (x << 40);
  endfunction

endpackage

[sv/fnvit_ram.sv]
module fnvit_ram #(
  parameter int Width = 64,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

[sv/fnv1a_hash_interning_table_top.sv]
// fnv-1a string interning table
// strings come in one byte per transaction on start_i / busy_o. a transaction
// is taken at a rising edge with start_i high and busy_o low. byte_present_i
// low means the transaction carries no byte (an empty string is one such
// transaction with last_i high). last_i closes the string.
// a byte that is not last leaves busy_o low, so such bytes can follow back
// to back. on the last transaction the block goes busy and walks the stored
// hashes in insertion order through the table ram, with a registered read,
// then a compare, for each stored entry. a string that matches entry k
// finishes at that compare; a new or rejected string finishes after it has
// been compared with all n stored entries.
// the result (index, hit flag, full flag, 64-bit hash) appears on the output
// ports for one cycle with done_o high; the receiver cannot stall it.
// a miss with room appends the hash; a miss on a full table sets table_full_o
// and stores nothing. reset empties the table (the entry count goes to zero,
// no ram clearing) and returns the running hash to the offset basis.
module fnv1a_hash_interning_table_top
  import fnvit_pkg::*;
#(
  parameter int TABLE_DEPTH = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [7:0]  data_byte_i,
  input  logic        byte_present_i,
  input  logic        last_i,
  output logic        done_o,
  output logic [7:0]  entry_index_o,
  output logic        already_present_o,
  output logic        table_full_o,
  output logic [63:0] text_hash_o
);

  localparam int AddrW = $clog2(TABLE_DEPTH);
  localparam int CntW  = $clog2(TABLE_DEPTH + 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(TABLE_DEPTH);

  typedef enum logic [1:0] {
    StIdle,
    StLook,
    StCmp
  } state_e;

  state_e          state_q;
  logic [63:0]     hash_q;
  logic [63:0]     key_q;
  logic [CntW-1:0] cnt_q;
  logic [CntW-1:0] idx_q;
  logic            done_q;
  logic [7:0]      index_q;
  logic            hit_q;
  logic            full_q;

  logic [63:0]     hash_d;
  logic            accept;
  logic            ram_we;
  logic [63:0]     ram_rdata;
  logic [CntW+7:0] idx_ext;
  logic [CntW+7:0] cnt_ext;

  assign accept = start_i && (state_q == StIdle);
  assign hash_d = byte_present_i ? fnv_round(hash_q, data_byte_i) : hash_q;

  // append on a miss with room
  assign ram_we = (state_q == StLook) && (idx_q == cnt_q) && (cnt_q != DepthCnt);

  assign idx_ext = {8'd0, idx_q};
  assign cnt_ext = {8'd0, cnt_q};

  fnvit_ram #(
    .Width (64),
    .Depth (TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cnt_q[AddrW-1:0]),
    .wdata_i (key_q),
    .raddr_i (idx_q[AddrW-1:0]),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      hash_q  <= FnvOffsetBasis;
      cnt_q   <= '0;
      idx_q   <= '0;
      done_q  <= 1'b0;
      index_q <= '0;
      hit_q   <= 1'b0;
      full_q  <= 1'b0;
      key_q   <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        StIdle: begin
          if (accept) begin
            if (last_i) begin
              key_q   <= hash_d;
              hash_q  <= FnvOffsetBasis;
              idx_q   <= '0;
              state_q <= StLook;
            end else begin
              hash_q <= hash_d;
            end
          end
        end
        StLook: begin
          if (idx_q == cnt_q) begin
            // searched every stored entry without a match
            done_q  <= 1'b1;
            hit_q   <= 1'b0;
            state_q <= StIdle;
            if (cnt_q != DepthCnt) begin
              index_q <= cnt_ext[7:0];
              full_q  <= 1'b0;
              cnt_q   <= cnt_q + 1'b1;
            end else begin
              index_q <= '0;
              full_q  <= 1'b1;
            end
          end else begin
            state_q <= StCmp;
          end
        end
        StCmp: begin
          if (ram_rdata == key_q) begin
            done_q  <= 1'b1;
            hit_q   <= 1'b1;
            full_q  <= 1'b0;
            index_q <= idx_ext[7:0];
            state_q <= StIdle;
          end else begin
            idx_q   <= idx_q + 1'b1;
            state_q <= StLook;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign busy_o            = (state_q != StIdle);
  assign done_o            = done_q;
  assign entry_index_o     = index_q;
  assign already_present_o = hit_q;
  assign table_full_o      = full_q;
  assign text_hash_o       = key_q;

endmodule

[sv/fnvit_checker.sv]
module fnvit_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic        last_i,
  input logic        done_o,
  input logic [7:0]  entry_index_o,
  input logic        already_present_o,
  input logic        table_full_o
);

  // a hit and a full table never come together
  a_hit_or_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(already_present_o && table_full_o))
    else $error("hit and full reported together");

  a_full_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && table_full_o) |-> (entry_index_o == 8'd0))
    else $error("full result with nonzero index");

  // a closing transaction starts the search
  a_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && last_i) |=> busy_o)
    else $error("closing transaction did not start search");

  // every result ends a search
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy_o))
    else $error("result without a search");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("results in consecutive cycles");

endmodule

bind fnv1a_hash_interning_table_top fnvit_checker u_fnvit_checker (.*);
